@@ rtl/lc3ie_pkg.sv @@
package lc3ie_pkg;

   localparam logic [3:0] OP_BR  = 4'h0;
   localparam logic [3:0] OP_ADD = 4'h1;
   localparam logic [3:0] OP_LD  = 4'h2;
   localparam logic [3:0] OP_ST  = 4'h3;
   localparam logic [3:0] OP_JSR = 4'h4;
   localparam logic [3:0] OP_AND = 4'h5;
   localparam logic [3:0] OP_LDR = 4'h6;
   localparam logic [3:0] OP_STR = 4'h7;
   localparam logic [3:0] OP_NOT = 4'h9;
   localparam logic [3:0] OP_LDI = 4'hA;
   localparam logic [3:0] OP_STI = 4'hB;
   localparam logic [3:0] OP_JMP = 4'hC;
   localparam logic [3:0] OP_LEA = 4'hE;

   localparam logic [2:0] CC_P = 3'b001;
   localparam logic [2:0] CC_Z = 3'b010;
   localparam logic [2:0] CC_N = 3'b100;

   localparam logic [2:0] LINK_REG = 3'd7;

   typedef struct packed {
      logic [15:0] instruction;
      logic [15:0] pc_incremented;
   } req_item_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        reg_written;
      logic [2:0]  reg_number;
      logic [15:0] reg_value;
      logic        mem_written;
      logic [15:0] mem_address;
      logic [15:0] mem_value;
      logic [2:0]  cond_code;
   } rsp_item_type;

   typedef struct packed {
      logic       en;
      logic [2:0] addr_a;
      logic [2:0] addr_b;
   } rf_read_type;

   typedef struct packed {
      logic        en;
      logic [2:0]  addr;
      logic [15:0] data;
   } rf_write_type;

   typedef struct packed {
      logic        en;
      logic [15:0] addr;
   } dm_read_type;

   typedef struct packed {
      logic        en;
      logic [15:0] addr;
      logic [15:0] data;
   } dm_write_type;

   function automatic logic [15:0] sext5(input logic [4:0] v);
      return {{11{v[4]}}, v};
   endfunction

   function automatic logic [15:0] sext6(input logic [5:0] v);
      return {{10{v[5]}}, v};
   endfunction

   function automatic logic [15:0] sext9(input logic [8:0] v);
      return {{7{v[8]}}, v};
   endfunction

   function automatic logic [15:0] sext11(input logic [10:0] v);
      return {{5{v[10]}}, v};
   endfunction

   function automatic logic [2:0] cc_of(input logic [15:0] v);
      logic [2:0] cc;
      if (v == 16'h0000) begin
         cc = CC_Z;
      end else if (v[15]) begin
         cc = CC_N;
      end else begin
         cc = CC_P;
      end
      return cc;
   endfunction

endpackage

@@ rtl/lc3ie_regfile.sv @@
module lc3ie_regfile
   import lc3ie_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rf_read_type  rd,
   input  rf_write_type wr,
   output logic [15:0]  rd_a_data,
   output logic [15:0]  rd_b_data
);

   logic [15:0] words_ff [8];
   logic [7:0]  valid_ff;
   logic [15:0] rd_a_ff;
   logic [15:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         words_ff[wr.addr] <= wr.data;
      end
   end

   // A write in the same cycle as the read is forwarded to the read data.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         if (wr.en && (wr.addr == rd.addr_a)) begin
            rd_a_ff <= wr.data;
         end else if (valid_ff[rd.addr_a]) begin
            rd_a_ff <= words_ff[rd.addr_a];
         end else begin
            rd_a_ff <= '0;
         end
         if (wr.en && (wr.addr == rd.addr_b)) begin
            rd_b_ff <= wr.data;
         end else if (valid_ff[rd.addr_b]) begin
            rd_b_ff <= words_ff[rd.addr_b];
         end else begin
            rd_b_ff <= '0;
         end
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

@@ rtl/lc3ie_dmem.sv @@
module lc3ie_dmem
   import lc3ie_pkg::*;
#(
   parameter int MEM_ADDR_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  dm_read_type  rd,
   input  dm_write_type wr,
   output logic [15:0]  rd_data,
   output logic         clearing
);

   localparam int Words = 1 << MEM_ADDR_BITS;

   logic [15:0]              words_ff [Words];
   logic [15:0]              rd_data_ff;
   logic                     clear_active_ff;
   logic [MEM_ADDR_BITS-1:0] clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
      end else if (clear_active_ff) begin
         clear_addr_ff <= clear_addr_ff + {{(MEM_ADDR_BITS-1){1'b0}}, 1'b1};
         if (&clear_addr_ff) begin
            clear_active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clear_active_ff) begin
         words_ff[clear_addr_ff] <= '0;
      end else if (wr.en) begin
         words_ff[wr.addr[MEM_ADDR_BITS-1:0]] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= words_ff[rd.addr[MEM_ADDR_BITS-1:0]];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clear_active_ff;

endmodule

@@ rtl/lc3_instruction_execute_core.sv @@
// Executes one LC-3 instruction per accepted beat and returns one result beat with the next
// program counter, any register write, any memory store and the condition code. Register
// operations, branches, jumps, LEA, ST and STR finish in the execute state; LD, LDR and STI
// also pass through the memory-read state ST_MEM1, and LDI through ST_MEM2 as well, set by the
// data memory's single registered read port. A new instruction is taken in the cycle the
// previous one completes, and a finished result waits in the output register without
// holding up the next instruction's register read. After reset the data memory is cleared
// one word per cycle, all 2**MEM_ADDR_BITS words, during which req_stall stays high.
module lc3_instruction_execute_core
   import lc3ie_pkg::*;
#(
   parameter int MEM_ADDR_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   localparam logic [15:0] MemMask = 16'((32'd1 << MEM_ADDR_BITS) - 32'd1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_MEM1 = 4'b0100,
      ST_MEM2 = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   logic [15:0]  ir_ff;
   logic [15:0]  pc_ff;
   logic [2:0]   cc_ff, cc_in;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;

   rf_read_type  rf_rd;
   rf_write_type rf_wr;
   dm_read_type  dm_rd;
   dm_write_type dm_wr;
   logic [15:0]  rd_a;
   logic [15:0]  rd_b;
   logic [15:0]  mem_data;
   logic         clearing;

   logic [3:0]   op;
   logic [15:0]  pc_off9;
   logic [15:0]  base_off6;
   logic [15:0]  operand_b;
   logic         done;
   logic         advance;
   logic         finish;
   logic         req_fire;
   logic         set_cc;
   rsp_item_type result;

   assign op        = ir_ff[15:12];
   assign pc_off9   = pc_ff + sext9(ir_ff[8:0]);
   assign base_off6 = rd_a + sext6(ir_ff[5:0]);
   assign operand_b = ir_ff[5] ? sext5(ir_ff[4:0]) : rd_b;

   always_comb begin
      result             = '0;
      result.next_pc     = pc_ff;
      set_cc             = 1'b0;
      done               = 1'b0;
      advance            = 1'b0;
      dm_rd              = '0;
      case (state_ff)
         ST_EXEC: begin
            done = 1'b1;
            case (op)
               OP_BR: begin
                  if ((ir_ff[11:9] & cc_ff) != 3'b000) begin
                     result.next_pc = pc_off9;
                  end
               end
               OP_ADD: begin
                  result.reg_written = 1'b1;
                  result.reg_number  = ir_ff[11:9];
                  result.reg_value   = rd_a + operand_b;
                  set_cc             = 1'b1;
               end
               OP_AND: begin
                  result.reg_written = 1'b1;
                  result.reg_number  = ir_ff[11:9];
                  result.reg_value   = rd_a & operand_b;
                  set_cc             = 1'b1;
               end
               OP_NOT: begin
                  result.reg_written = 1'b1;
                  result.reg_number  = ir_ff[11:9];
                  result.reg_value   = ~rd_a;
                  set_cc             = 1'b1;
               end
               OP_LEA: begin
                  result.reg_written = 1'b1;
                  result.reg_number  = ir_ff[11:9];
                  result.reg_value   = pc_off9;
                  set_cc             = 1'b1;
               end
               OP_JMP: begin
                  result.next_pc = rd_a;
               end
               OP_JSR: begin
                  result.next_pc     = ir_ff[11] ? (pc_ff + sext11(ir_ff[10:0])) : rd_a;
                  result.reg_written = 1'b1;
                  result.reg_number  = LINK_REG;
                  result.reg_value   = pc_ff;
               end
               OP_ST: begin
                  result.mem_written = 1'b1;
                  result.mem_address = pc_off9 & MemMask;
                  result.mem_value   = rd_b;
               end
               OP_STR: begin
                  result.mem_written = 1'b1;
                  result.mem_address = base_off6 & MemMask;
                  result.mem_value   = rd_b;
               end
               OP_LD, OP_LDI, OP_STI: begin
                  done       = 1'b0;
                  advance    = 1'b1;
                  dm_rd.en   = 1'b1;
                  dm_rd.addr = pc_off9;
               end
               OP_LDR: begin
                  done       = 1'b0;
                  advance    = 1'b1;
                  dm_rd.en   = 1'b1;
                  dm_rd.addr = base_off6;
               end
               default: begin
               end
            endcase
         end
         ST_MEM1: begin
            case (op)
               OP_LDI: begin
                  advance    = 1'b1;
                  dm_rd.en   = 1'b1;
                  dm_rd.addr = mem_data;
               end
               OP_STI: begin
                  done               = 1'b1;
                  result.mem_written = 1'b1;
                  result.mem_address = mem_data & MemMask;
                  result.mem_value   = rd_b;
               end
               default: begin
                  done               = 1'b1;
                  result.reg_written = 1'b1;
                  result.reg_number  = ir_ff[11:9];
                  result.reg_value   = mem_data;
                  set_cc             = 1'b1;
               end
            endcase
         end
         ST_MEM2: begin
            done               = 1'b1;
            result.reg_written = 1'b1;
            result.reg_number  = ir_ff[11:9];
            result.reg_value   = mem_data;
            set_cc             = 1'b1;
         end
         default: begin
         end
      endcase
      cc_in            = set_cc ? cc_of(result.reg_value) : cc_ff;
      result.cond_code = cc_in;
   end

   assign finish    = done && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clearing || !((state_ff == ST_IDLE) || finish);
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      rf_rd.en     = req_fire;
      rf_rd.addr_a = req_item.instruction[8:6];
      case (req_item.instruction[15:12])
         OP_ST, OP_STI, OP_STR: rf_rd.addr_b = req_item.instruction[11:9];
         default:               rf_rd.addr_b = req_item.instruction[2:0];
      endcase
   end

   assign rf_wr.en   = finish && result.reg_written;
   assign rf_wr.addr = result.reg_number;
   assign rf_wr.data = result.reg_value;

   assign dm_wr.en   = finish && result.mem_written;
   assign dm_wr.addr = result.mem_address;
   assign dm_wr.data = result.mem_value;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC, ST_MEM1, ST_MEM2: begin
            if (advance) begin
               state_in = (state_ff == ST_EXEC) ? ST_MEM1 : ST_MEM2;
            end else if (finish) begin
               state_in = req_fire ? ST_EXEC : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cc_ff        <= CC_Z;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            cc_ff        <= cc_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ir_ff <= req_item.instruction;
         pc_ff <= req_item.pc_incremented;
      end
      if (finish) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   lc3ie_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd        (rf_rd),
      .wr        (rf_wr),
      .rd_a_data (rd_a),
      .rd_b_data (rd_b)
   );

   lc3ie_dmem #(
      .MEM_ADDR_BITS (MEM_ADDR_BITS)
   ) u_dmem (
      .clock    (clock),
      .reset    (reset),
      .rd       (dm_rd),
      .wr       (dm_wr),
      .rd_data  (mem_data),
      .clearing (clearing)
   );

endmodule

@@ test/tb_lc3_instruction_execute_core.sv @@
module tb_lc3_instruction_execute_core;
   import lc3ie_pkg::*;

   localparam int MEM_BITS = 16;
   localparam logic [15:0] ADDR_MASK = 16'((32'd1 << MEM_BITS) - 1);
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_INSTRS = 950;

   localparam logic [3:0] OP_RTI  = 4'h8;
   localparam logic [3:0] OP_RESV = 4'hD;
   localparam logic [3:0] OP_TRAP = 4'hF;

   typedef struct {
      req_item_type beat;
      bit           drain;
   } instr_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   instr_entry_type instr_fifo[$];
   rsp_item_type    predicted_effects[$];

   logic [15:0] gpr[8];
   logic [2:0]  flags;
   logic [15:0] dmem[1 << MEM_BITS];

   bit req_accepted = 1'b0;
   bit rsp_accepted = 1'b0;
   int send_gap = 0;
   int send_calm = 0;
   int recv_hold = 0;
   int recv_calm = 0;
   int cycles = 0;
   int mismatches = 0;
   int executed = 0;
   int checked = 0;
   int stores_seen = 0;
   int writes_seen = 0;
   int op_seen[16];

   lc3_instruction_execute_core #(
      .MEM_ADDR_BITS(MEM_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [15:0] sign_field(input logic [15:0] v, input int bits);
      logic signed [15:0] t;
      t = v << (16 - bits);
      return 16'(t >>> (16 - bits));
   endfunction

   function automatic logic [15:0] mem_word(input logic [15:0] a);
      return dmem[a & ADDR_MASK];
   endfunction

   function automatic int draw_wait(inout int calm);
      int n;
      n = 0;
      if (calm > 0) begin
         calm--;
      end else if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
      end else begin
         n = $urandom_range(0, 18);
      end
      return n;
   endfunction

   function automatic rsp_item_type execute_instruction(input req_item_type b);
      rsp_item_type r;
      logic [15:0] ir, pc, off9, off6, operand;
      logic [3:0]  op;
      logic [2:0]  dst, src1;
      bit          set_flags;
      ir = b.instruction;
      pc = b.pc_incremented;
      op = ir[15:12];
      dst = ir[11:9];
      src1 = ir[8:6];
      off9 = sign_field(ir, 9);
      off6 = sign_field(ir, 6);
      set_flags = 1'b1;
      r = '0;
      r.next_pc = pc;
      case (op)
         OP_BR: begin
            if ((ir[11:9] & flags) != 3'b000) r.next_pc = pc + off9;
         end
         OP_ADD, OP_AND: begin
            operand = ir[5] ? sign_field(ir, 5) : gpr[ir[2:0]];
            r.reg_value = (op == OP_ADD) ? gpr[src1] + operand : gpr[src1] & operand;
            r.reg_written = 1'b1;
            r.reg_number = dst;
         end
         OP_NOT: begin
            r.reg_value = ~gpr[src1];
            r.reg_written = 1'b1;
            r.reg_number = dst;
         end
         OP_LD, OP_LDI, OP_LDR, OP_LEA: begin
            case (op)
               OP_LD:   r.reg_value = mem_word(pc + off9);
               OP_LDI:  r.reg_value = mem_word(mem_word(pc + off9));
               OP_LDR:  r.reg_value = mem_word(gpr[src1] + off6);
               default: r.reg_value = pc + off9;
            endcase
            r.reg_written = 1'b1;
            r.reg_number = dst;
         end
         OP_ST, OP_STI, OP_STR: begin
            case (op)
               OP_ST:   r.mem_address = (pc + off9) & ADDR_MASK;
               OP_STI:  r.mem_address = mem_word(pc + off9) & ADDR_MASK;
               default: r.mem_address = (gpr[src1] + off6) & ADDR_MASK;
            endcase
            r.mem_written = 1'b1;
            r.mem_value = gpr[dst];
         end
         OP_JMP: begin
            r.next_pc = gpr[src1];
         end
         OP_JSR: begin
            r.next_pc = ir[11] ? pc + sign_field(ir, 11) : gpr[src1];
            r.reg_written = 1'b1;
            r.reg_number = LINK_REG;
            r.reg_value = pc;
            set_flags = 1'b0;
         end
         default: begin
         end
      endcase
      if (r.reg_written) begin
         gpr[r.reg_number] = r.reg_value;
         if (set_flags) begin
            flags = (r.reg_value == 16'h0000) ? CC_Z : (r.reg_value[15] ? CC_N : CC_P);
         end
         writes_seen++;
      end
      if (r.mem_written) begin
         dmem[r.mem_address] = r.mem_value;
         stores_seen++;
      end
      r.cond_code = flags;
      op_seen[op]++;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic add_instr(input logic [15:0] ir, input logic [15:0] pc, input bit drain);
      instr_entry_type e;
      e.beat.instruction = ir;
      e.beat.pc_incremented = pc;
      e.drain = drain;
      instr_fifo.push_back(e);
   endtask

   // Each beat is sampled at the rising edge; the result side is handled before the
   // instruction side so a result always meets the prediction of an earlier beat.
   always @(posedge clock) begin
      rsp_item_type want;
      cycles++;
      req_accepted = !reset && req_valid && !req_stall;
      rsp_accepted = !reset && rsp_valid && !rsp_stall;
      if (rsp_accepted) begin
         checked++;
         if (predicted_effects.size() == 0) begin
            $error("result beat arrived with no instruction outstanding");
            mismatches++;
         end else begin
            want = predicted_effects.pop_front();
            check_field("next_pc", want.next_pc, rsp_item.next_pc);
            check_field("reg_written", 16'(want.reg_written), 16'(rsp_item.reg_written));
            check_field("reg_number", 16'(want.reg_number), 16'(rsp_item.reg_number));
            check_field("reg_value", want.reg_value, rsp_item.reg_value);
            check_field("mem_written", 16'(want.mem_written), 16'(rsp_item.mem_written));
            check_field("mem_address", want.mem_address, rsp_item.mem_address);
            check_field("mem_value", want.mem_value, rsp_item.mem_value);
            check_field("cond_code", 16'(want.cond_code), 16'(rsp_item.cond_code));
         end
      end
      if (req_accepted) begin
         predicted_effects.push_back(execute_instruction(req_item));
         executed++;
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (!req_valid || req_accepted) begin
         if (req_valid) send_gap = draw_wait(send_calm);
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (instr_fifo.size() != 0 &&
                      !(instr_fifo[0].drain && predicted_effects.size() != 0)) begin
            req_item <= instr_fifo[0].beat;
            void'(instr_fifo.pop_front());
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_accepted) recv_hold = draw_wait(recv_calm);
      if (recv_hold > 0) begin
         recv_hold--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      logic [15:0] ir, pc;
      int ops_hit;
      for (int i = 0; i < 8; i++) gpr[i] = 16'h0000;
      for (int i = 0; i < (1 << MEM_BITS); i++) dmem[i] = 16'h0000;
      for (int i = 0; i < 16; i++) op_seen[i] = 0;
      flags = CC_Z;

      add_instr({OP_BR, 3'b000, 9'h1FF}, 16'h3001, 1'b0);
      add_instr({OP_BR, 3'b010, 9'h0FF}, 16'hFFFF, 1'b0);
      add_instr({OP_NOT, 3'd0, 3'd0, 6'h3F}, 16'h3002, 1'b0);
      add_instr({OP_ADD, 3'd1, 3'd0, 1'b1, 5'h10}, 16'h3003, 1'b0);
      add_instr({OP_ADD, 3'd2, 3'd0, 1'b0, 2'b11, 3'd1}, 16'h3004, 1'b0);
      add_instr({OP_AND, 3'd3, 3'd0, 1'b1, 5'h0F}, 16'h3005, 1'b0);
      add_instr({OP_AND, 3'd4, 3'd3, 1'b0, 2'b00, 3'd1}, 16'h3006, 1'b0);
      add_instr({OP_AND, 3'd6, 3'd0, 1'b1, 5'h00}, 16'h3007, 1'b0);
      add_instr({OP_BR, 3'b101, 9'h100}, 16'h3008, 1'b0);
      add_instr({OP_LEA, 3'd5, 9'h0FF}, 16'hFFFF, 1'b0);
      add_instr({OP_LEA, 3'd6, 9'h100}, 16'h0000, 1'b0);
      add_instr({OP_ST, 3'd5, 9'h010}, 16'h3000, 1'b0);
      add_instr({OP_STI, 3'd0, 9'h010}, 16'h3000, 1'b1);
      add_instr({OP_LDI, 3'd7, 9'h010}, 16'h3000, 1'b0);
      add_instr({OP_LD, 3'd2, 9'h1F0}, 16'h3020, 1'b0);
      add_instr({OP_STR, 3'd1, 3'd5, 6'h1F}, 16'h3021, 1'b0);
      add_instr({OP_STR, 3'd3, 3'd6, 6'h20}, 16'h3022, 1'b0);
      add_instr({OP_LDR, 3'd4, 3'd5, 6'h1F}, 16'h3023, 1'b0);
      add_instr({OP_JMP, 3'd0, 3'd0, 6'h00}, 16'h3024, 1'b0);
      add_instr({OP_JMP, 3'd0, 3'd7, 6'h00}, 16'h3025, 1'b0);
      add_instr({OP_JSR, 1'b1, 11'h3FF}, 16'h8000, 1'b0);
      add_instr({OP_JSR, 1'b1, 11'h400}, 16'h0100, 1'b0);
      add_instr({OP_JSR, 1'b0, 2'b00, 3'd7, 6'h00}, 16'h4000, 1'b0);
      add_instr({OP_TRAP, 12'hFFF}, 16'h4001, 1'b0);
      add_instr({OP_RTI, 12'h000}, 16'h4002, 1'b0);
      add_instr({OP_RESV, 12'hABC}, 16'h4003, 1'b0);

      // Most instructions run near one code window so that loads, stores and pointers
      // keep landing on words that earlier instructions wrote.
      for (int i = 0; i < RANDOM_INSTRS; i++) begin
         ir = 16'($urandom);
         pc = 16'($urandom);
         if ($urandom_range(0, 99) < 75) pc = 16'h3000 + 16'($urandom_range(0, 63));
         add_instr(ir, pc, $urandom_range(0, 99) == 0);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (instr_fifo.size() != 0 || req_valid) @(posedge clock);
      while (predicted_effects.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      ops_hit = 0;
      for (int i = 0; i < 16; i++) if (op_seen[i] != 0) ops_hit++;
      $display("%0d instructions over %0d of 16 opcodes, %0d results compared",
               executed, ops_hit, checked);
      $display("%0d register writes and %0d memory stores predicted", writes_seen,
               stores_seen);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/lc3ie_pkg.sv
rtl/lc3ie_regfile.sv
rtl/lc3ie_dmem.sv
rtl/lc3_instruction_execute_core.sv
test/tb_lc3_instruction_execute_core.sv
